/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the TLV element search RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/tlvs_pkg.sv */
// ----------------------------------------------------------------------------
// tlvs_pkg
// Types and constants for the TLV element search block.
// ----------------------------------------------------------------------------
package tlvs_pkg;

    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TYPE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE   = 1'd1;

    typedef enum logic
    {
        PHASE_HEADER = 1'b0,
        PHASE_SKIP   = 1'b1
    } scan_phase_t;

    typedef struct packed
    {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [15:0] msg_len;
    } in_item_t;

    typedef struct packed
    {
        logic        found;
        logic [15:0] element_offset;
        logic [15:0] value_length;
    } out_item_t;

    typedef struct packed
    {
        logic [15:0] search_type;
        logic        wide_header_mode;
    } cfg_t;

    // Handshake status between the input register and the scan stage
    typedef struct packed
    {
        logic item_valid;
    } pipe_ctl_t;

endpackage

/* rtl/tlvs_in_reg.sv */
// ----------------------------------------------------------------------------
// tlvs_in_reg
// Input request register; holds one byte until the scan stage takes it.
// ----------------------------------------------------------------------------
module tlvs_in_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tlvs_pkg::in_item_t in_data,
    input  logic               out_free,
    output tlvs_pkg::pipe_ctl_t ctl,
    output tlvs_pkg::in_item_t item
);
    import tlvs_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;
    logic     consume;

    assign consume  = valid_reg && out_free;
    assign in_stall = valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
    end

    assign ctl.item_valid = consume;
    assign item           = item_reg;

endmodule

/* rtl/tlvs_scan.sv */
// ----------------------------------------------------------------------------
// tlvs_scan
// Per-byte scan state and the single-pass TLV header/skip decision.
// ----------------------------------------------------------------------------
module tlvs_scan
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlvs_pkg::cfg_t       cfg,
    input  tlvs_pkg::pipe_ctl_t  ctl,
    input  tlvs_pkg::in_item_t   item,
    output logic                 res_fire,
    output tlvs_pkg::out_item_t  res
);
    import tlvs_pkg::*;

    scan_phase_t phase_reg, phase_next;
    logic        decided_reg, decided_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] pos_reg, pos_next;
    logic [1:0]  hbc_reg, hbc_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] skip_reg, skip_next;

    always_comb
    begin
        logic        live;
        logic [1:0]  half;
        logic        complete;
        logic [15:0] mask;
        logic [15:0] elen;
        logic [15:0] etype;

        phase_next   = phase_reg;
        decided_next = decided_reg;
        remain_next  = remain_reg;
        pos_next     = pos_reg;
        hbc_next     = hbc_reg;
        type_next    = type_reg;
        len_next     = len_reg;
        start_next   = start_reg;
        skip_next    = skip_reg;
        res_fire     = 1'b0;
        res          = '0;
        live         = 1'b0;
        half         = cfg.wide_header_mode ? 2'd2 : 2'd1;
        mask         = cfg.wide_header_mode ? 16'hFFFF : 16'h00FF;
        complete     = 1'b0;
        elen         = '0;
        etype        = '0;

        if (ctl.item_valid)
        begin
            live = 1'b1;
            if (item.first_byte)
            begin
                decided_next = 1'b0;
                phase_next   = PHASE_HEADER;
                remain_next  = item.msg_len;
                pos_next     = '0;
                hbc_next     = '0;
                skip_next    = '0;
                // empty message: decide at once, byte is not scanned
                if (item.msg_len == 16'd0)
                begin
                    decided_next = 1'b1;
                    res_fire     = 1'b1;
                    live         = 1'b0;
                end
            end

            if (live && !decided_next)
            begin
                remain_next = remain_next - 16'd1;
                if (phase_next == PHASE_SKIP)
                begin
                    pos_next  = pos_next + 16'd1;
                    skip_next = skip_next - 16'd1;
                    if (skip_next == 16'd0)
                    begin
                        if (remain_next == 16'd0)
                        begin
                            decided_next = 1'b1;
                            res_fire     = 1'b1;
                        end
                        else
                        begin
                            phase_next = PHASE_HEADER;
                            hbc_next   = '0;
                        end
                    end
                end
                else
                begin
                    if (hbc_next == 2'd0)
                    begin
                        start_next = pos_next;
                        type_next  = '0;
                        len_next   = '0;
                    end
                    if (hbc_next < half)
                    begin
                        type_next = {type_next[7:0], item.data_byte};
                    end
                    else
                    begin
                        len_next = {len_next[7:0], item.data_byte};
                    end
                    hbc_next = hbc_next + 2'd1;
                    pos_next = pos_next + 16'd1;
                    // the count wraps to zero after the fourth wide header byte
                    complete = (hbc_next == 2'd0) ||
                               (!cfg.wide_header_mode && hbc_next >= 2'd2);

                    if (!complete)
                    begin
                        if (remain_next == 16'd0)
                        begin
                            decided_next = 1'b1;
                            res_fire     = 1'b1;
                        end
                    end
                    else
                    begin
                        elen     = len_next & mask;
                        etype    = type_next & mask;
                        hbc_next = '0;
                        if (elen > remain_next)
                        begin
                            decided_next = 1'b1;
                            res_fire     = 1'b1;
                        end
                        else if (etype == (cfg.search_type & mask))
                        begin
                            decided_next       = 1'b1;
                            res_fire           = 1'b1;
                            res.found          = 1'b1;
                            res.element_offset = start_next;
                            res.value_length   = elen;
                        end
                        else if (elen == 16'd0)
                        begin
                            if (remain_next == 16'd0)
                            begin
                                decided_next = 1'b1;
                                res_fire     = 1'b1;
                            end
                        end
                        else
                        begin
                            skip_next  = elen;
                            phase_next = PHASE_SKIP;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PHASE_HEADER;
            decided_reg <= 1'b1;
            remain_reg  <= '0;
            pos_reg     <= '0;
            hbc_reg     <= '0;
            type_reg    <= '0;
            len_reg     <= '0;
            start_reg   <= '0;
            skip_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            decided_reg <= decided_next;
            remain_reg  <= remain_next;
            pos_reg     <= pos_next;
            hbc_reg     <= hbc_next;
            type_reg    <= type_next;
            len_reg     <= len_next;
            start_reg   <= start_next;
            skip_reg    <= skip_next;
        end
    end

endmodule

/* rtl/tlvs_out_reg.sv */
// ----------------------------------------------------------------------------
// tlvs_out_reg
// Result register; holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module tlvs_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_fire,
    input  tlvs_pkg::out_item_t res,
    output logic                out_free,
    output logic                out_valid,
    input  logic                out_stall,
    output tlvs_pkg::out_item_t out_data
);
    import tlvs_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign out_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_fire)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/tlv_element_search.sv */
// ----------------------------------------------------------------------------
// tlv_element_search
// Scans a byte stream as TLV elements and reports the first matching type.
// ----------------------------------------------------------------------------
// One message byte per request, one request per cycle while in_stall is low.
// A byte is held in the input register, the header/skip decision is made from
// it and the scan state in a single pass, and the result is captured in the
// result register.
// Each message gives exactly one result: found with the header offset and
// length field, or not found. Bytes after the decision are dropped until the
// next request marked as first byte. in_stall rises only while a result waits
// in the result register under out_stall. Write search_type and
// wide_header_mode only while no request is in flight; a change applies at
// once, even in the middle of a message.
// ----------------------------------------------------------------------------
module tlv_element_search
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  tlvs_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output tlvs_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [tlvs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [15:0]                         cfg_wdata
);
    import tlvs_pkg::*;

    `include "assert_macros.svh"

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    pipe_ctl_t ctl;
    in_item_t  item;
    logic      out_free;
    logic      res_fire;
    out_item_t res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEARCH_TYPE: cfg_next.search_type      = cfg_wdata;
                CFG_WIDE_MODE:   cfg_next.wide_header_mode = cfg_wdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tlvs_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_free (out_free),
        .ctl      (ctl),
        .item     (item)
    );

    tlvs_scan u_scan
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .ctl      (ctl),
        .item     (item),
        .res_fire (res_fire),
        .res      (res)
    );

    tlvs_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_fire  (res_fire),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // a result is only produced when the result register can take it
    `ASSERT_SAME(a_fire_has_room, clk, rst_n, res_fire, out_free && ctl.item_valid)
    // back-pressure only comes from a held result
    `ASSERT_SAME(a_stall_source, clk, rst_n, in_stall, out_valid && out_stall)
    // a fired result is presented on the next cycle
    `ASSERT_NEXT(a_fire_shows, clk, rst_n, res_fire, out_valid)
    // not-found results carry zero offset and length
    `ASSERT_SAME(a_miss_zero, clk, rst_n, out_valid && !out_data.found, out_data.element_offset == 16'd0 && out_data.value_length == 16'd0)

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for tlv_element_search. Byte requests are driven as
// TLV chains in both header modes: hits, misses, overruns, cut headers,
// noise, empty messages and idle bytes. An in-bench scan model predicts the
// single result of each message, and every result taken from the block is
// compared with it field by field, under random bursts and output stalls.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tlvs_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int RANDOM_PHASES   = 6;

    class search_scoreboard;
        logic [15:0] search_type;
        bit          wide;
        scan_phase_t phase;
        bit          decided;
        bit [15:0]   remaining;
        bit [15:0]   position;
        bit [1:0]    hdr_count;
        bit [15:0]   type_acc;
        bit [15:0]   len_acc;
        bit [15:0]   elem_start;
        bit [15:0]   skip_left;
        out_item_t   results_q[$];
        int          errors;

        function new();
            search_type = '0;
            wide        = 1'b0;
            phase       = PHASE_HEADER;
            decided     = 1'b1;
            remaining   = '0;
            position    = '0;
            hdr_count   = '0;
            type_acc    = '0;
            len_acc     = '0;
            elem_start  = '0;
            skip_left   = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [15:0] value);
            if (index == CFG_SEARCH_TYPE)
                search_type = value;
            else if (index == CFG_WIDE_MODE)
                wide = value[0];
        endfunction

        function int pending();
            return results_q.size();
        endfunction

        function void close_message(bit hit, bit [15:0] offset, bit [15:0] vlen);
            out_item_t res;
            decided            = 1'b1;
            res.found          = hit;
            res.element_offset = hit ? offset : 16'd0;
            res.value_length   = hit ? vlen : 16'd0;
            results_q.push_back(res);
        endfunction

        // Returns 1 when the byte takes part in a message, 0 when it is dropped.
        function bit note_request(in_item_t req);
            int unsigned hsize;
            bit [15:0]   hmask;
            bit [15:0]   vlen;
            bit [15:0]   vtype;
            hsize = wide ? 4 : 2;
            hmask = wide ? 16'hFFFF : 16'h00FF;
            if (req.first_byte)
            begin
                decided   = 1'b0;
                phase     = PHASE_HEADER;
                remaining = req.msg_len;
                position  = '0;
                hdr_count = '0;
                skip_left = '0;
                if (remaining == 0)
                begin
                    close_message(1'b0, '0, '0);
                    return 1'b1;
                end
            end
            if (decided)
                return 1'b0;

            remaining--;
            if (phase == PHASE_SKIP)
            begin
                position++;
                skip_left--;
                if (skip_left == 0)
                begin
                    if (remaining == 0)
                        close_message(1'b0, '0, '0);
                    else
                    begin
                        phase     = PHASE_HEADER;
                        hdr_count = '0;
                    end
                end
                return 1'b1;
            end

            if (hdr_count == 0)
            begin
                elem_start = position;
                type_acc   = '0;
                len_acc    = '0;
            end
            if (hdr_count < hsize / 2)
                type_acc = {type_acc[7:0], req.data_byte};
            else
                len_acc = {len_acc[7:0], req.data_byte};
            hdr_count++;
            position++;

            if (hdr_count != 0 && hdr_count < hsize)
            begin
                // header cut short by the end of the message
                if (remaining == 0)
                    close_message(1'b0, '0, '0);
                return 1'b1;
            end

            vlen      = len_acc & hmask;
            vtype     = type_acc & hmask;
            hdr_count = '0;
            if (vlen > remaining)
                close_message(1'b0, '0, '0);
            else if (vtype == (search_type & hmask))
                close_message(1'b1, elem_start, vlen);
            else if (vlen == 0)
            begin
                if (remaining == 0)
                    close_message(1'b0, '0, '0);
            end
            else
            begin
                skip_left = vlen;
                phase     = PHASE_SKIP;
            end
            return 1'b1;
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (results_q.size() == 0)
            begin
                $error("unexpected result: found=%0d offset=%0d length=%0d",
                       got.found, got.element_offset, got.value_length);
                errors++;
                return;
            end
            want = results_q.pop_front();
            if (got.found !== want.found)
            begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                errors++;
            end
            if (got.element_offset !== want.element_offset)
            begin
                $error("element_offset: expected %0d, actual %0d",
                       want.element_offset, got.element_offset);
                errors++;
            end
            if (got.value_length !== want.value_length)
            begin
                $error("value_length: expected %0d, actual %0d",
                       want.value_length, got.value_length);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_item_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_wdata;

    search_scoreboard sb;
    logic [7:0]       msg_bytes[$];
    int               burst_left;
    int               scanned;
    int               cycle_count;
    bit               hold_off_go;
    logic [15:0]      cur_type;
    bit               cur_wide;

    tlv_element_search i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Output stall pattern, with one long hold-off once the random part starts
    initial
    begin
        int seg_left;
        int style;
        bit hold_done;
        out_stall = 1'b0;
        seg_left  = 0;
        style     = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_go && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else
            begin
                if (seg_left == 0)
                begin
                    style    = $urandom_range(0, 2);
                    seg_left = $urandom_range(10, 60);
                end
                seg_left--;
                case (style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
                sb.check_result(out_data);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic put_byte(input logic [7:0] data, input bit first, input logic [15:0] mlen);
        in_item_t req;
        req.data_byte  = data;
        req.first_byte = first;
        req.msg_len    = first ? mlen : 16'($urandom);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
        void'(sb.note_request(req));
        scanned++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_msg(input logic [15:0] mlen, input bit start);
        foreach (msg_bytes[i])
            put_byte(msg_bytes[i], start && i == 0, mlen);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe drain.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(input logic [15:0] stype, input bit wide);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SEARCH_TYPE;
        cfg_wdata <= stype;
        sb.write_reg(CFG_SEARCH_TYPE, stype);
        @(negedge clk);
        cfg_index <= CFG_WIDE_MODE;
        cfg_wdata <= {15'($urandom), wide};
        sb.write_reg(CFG_WIDE_MODE, {15'd0, wide});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void add_element(logic [15:0] etype, logic [15:0] elen, bit with_value);
        if (cur_wide)
        begin
            msg_bytes.push_back(etype[15:8]);
            msg_bytes.push_back(etype[7:0]);
            msg_bytes.push_back(elen[15:8]);
            msg_bytes.push_back(elen[7:0]);
        end
        else
        begin
            msg_bytes.push_back(etype[7:0]);
            msg_bytes.push_back(elen[7:0]);
        end
        if (with_value)
            repeat (elen) msg_bytes.push_back(8'($urandom));
    endfunction

    function automatic logic [15:0] other_type();
        logic [15:0] t;
        logic [15:0] m;
        m = cur_wide ? 16'hFFFF : 16'h00FF;
        t = 16'($urandom);
        if ((t & m) == (cur_type & m))
            t ^= 16'h0001;
        return t;
    endfunction

    function automatic logic [15:0] short_len();
        if ($urandom_range(0, 19) == 0)
            return 16'($urandom_range(6, 40));
        return 16'($urandom_range(0, 5));
    endfunction

    task automatic send_random_message();
        int          pick;
        int          n;
        int          hit_at;
        int          hsize;
        logic [15:0] elen;
        logic [15:0] mlen;
        pick  = $urandom_range(0, 99);
        hsize = cur_wide ? 4 : 2;
        msg_bytes.delete();
        if (pick < 55)
        begin
            // well-formed chain, match somewhere or nowhere
            n      = $urandom_range(1, 4);
            hit_at = $urandom_range(0, n);
            for (int i = 0; i < n; i++)
                add_element((i == hit_at) ? cur_type : other_type(), short_len(), 1'b1);
            send_msg(16'(msg_bytes.size()), 1'b1);
            if ($urandom_range(0, 4) == 0)
            begin
                msg_bytes.delete();
                repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom));
                send_msg(16'd0, 1'b0);
            end
        end
        else if (pick < 75)
        begin
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                add_element(other_type(), short_len(), 1'b1);
            if (pick < 65)
            begin
                // last element runs past the end of the message
                elen = cur_wide ? 16'($urandom_range(1, 600)) : 16'($urandom_range(1, 255));
                add_element($urandom_range(0, 1) ? cur_type : other_type(), elen, 1'b0);
                mlen = 16'(msg_bytes.size() + $urandom_range(0, elen - 1));
            end
            else
            begin
                repeat ($urandom_range(1, hsize - 1)) msg_bytes.push_back(8'($urandom));
                mlen = 16'(msg_bytes.size());
            end
            send_msg(mlen, 1'b1);
        end
        else if (pick < 85)
        begin
            mlen = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 24));
            repeat ($urandom_range(1, 24)) msg_bytes.push_back(8'($urandom));
            send_msg(mlen, 1'b1);
        end
        else if (pick < 92)
        begin
            repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom));
            send_msg(16'd0, 1'b1);
        end
        else
        begin
            repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom));
            send_msg(16'd0, 1'b0);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        burst_left  = 0;
        scanned     = 0;
        hold_off_go = 1'b0;
        sb          = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // narrow headers; upper type bits must not matter
        cur_type = 16'h12A5;
        cur_wide = 1'b0;
        set_config(cur_type, cur_wide);
        msg_bytes = '{8'hFF};
        send_msg(16'd0, 1'b0);
        msg_bytes = '{8'h00};
        send_msg(16'd0, 1'b1);
        msg_bytes = '{8'h01, 8'h01, 8'hAA, 8'hA5, 8'h02};
        send_msg(16'd7, 1'b1);
        msg_bytes = '{8'h00, 8'h00, 8'hFF, 8'h00};
        send_msg(16'd4, 1'b1);
        msg_bytes = '{8'hA5, 8'hFF};
        send_msg(16'd3, 1'b1);
        msg_bytes = '{8'h01, 8'h00, 8'h07};
        send_msg(16'd3, 1'b1);
        settle();

        // wide headers, longest message
        cur_type = 16'hFFFF;
        cur_wide = 1'b1;
        set_config(cur_type, cur_wide);
        msg_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFB};
        send_msg(16'hFFFF, 1'b1);
        // switch to narrow headers halfway through a wide header
        msg_bytes = '{8'h12, 8'h34};
        send_msg(16'd10, 1'b1);
        settle();
        cur_wide = 1'b0;
        set_config(cur_type, cur_wide);
        msg_bytes = '{8'h00, 8'hFF, 8'h03};
        send_msg(16'd0, 1'b0);
        settle();

        hold_off_go = 1'b1;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       begin cur_type = 16'h0000;          cur_wide = 1'b0; end
                1:       begin cur_type = 16'hFFFF;          cur_wide = 1'b1; end
                2:       begin cur_type = 16'($urandom);     cur_wide = 1'b1; end
                3:       begin cur_type = 16'h5AFF;          cur_wide = 1'b0; end
                4:       begin cur_type = 16'h0000;          cur_wide = 1'b1; end
                default: begin cur_type = 16'($urandom);     cur_wide = 1'b0; end
            endcase
            set_config(cur_type, cur_wide);
            scanned = 0;
            while (scanned < ITEMS_PER_PHASE)
                send_random_message();
            // close any open message with an empty one
            msg_bytes = '{8'($urandom)};
            send_msg(16'd0, 1'b1);
            settle();
        end

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
